// ===== rtl/mtaf_pkg.sv =====
// Shared types and constants for the mesh triangle artifact filter.
`timescale 1ns / 1ps
`default_nettype none
package mtaf_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RATIO     = 2'd0;
  localparam logic [1:0] REG_PERIMETER = 2'd1;
  localparam logic [1:0] REG_INCIDENCE = 2'd2;

  localparam int RATIO_W = 16;
  localparam int PERIM_W = 26;
  localparam int INCID_W = 15;
  localparam int CFG_W   = 26;
  localparam int NORM_W  = 16;

  // Side differences at or above 2^SIDE_LOG always fail the perimeter test
  localparam int SIDE_LOG = 26;
  // Root bits of a Q.4 side length (radicand below 2^62)
  localparam int ROOT_W   = 31;
  localparam int RAD_W    = 62;

  typedef enum logic [1:0] {
    CAUSE_KEPT      = 2'd0,
    CAUSE_RATIO     = 2'd1,
    CAUSE_PERIMETER = 2'd2,
    CAUSE_INCIDENCE = 2'd3
  } cause_t;

  typedef struct packed {
    logic ratio_fail;
    logic incid_fail;
  } flags_t;

endpackage
`default_nettype wire

// ===== rtl/mesh_triangle_artifact_filter.sv =====
// Top level: pipelined triangle artifact filter (ratio, perimeter, incidence tests).
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------------------
//  input   | in_first_x .. in_normal_z              | start high, busy low at clk edge
//  result  | out_keep, out_reject_cause             | out_valid, one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_data            | write at clk edge with cfg_we
//
// One item is taken every cycle.
// The latency is set by the three side-length square roots, one root bit per stage
// (31 stages) after three stages of squares, products and sums.
// Reset (synchronous, rst_n low) clears the valid line and the limit registers.
// busy is never raised: the pipeline has no stall, the receiver takes every result.
// Limit changes reach the squared-limit registers in the cycle after a write.
`timescale 1ns / 1ps
`default_nettype none
module mesh_triangle_artifact_filter
  import mtaf_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire signed [COORD_WIDTH-1:0] in_first_x,
  input  wire signed [COORD_WIDTH-1:0] in_first_y,
  input  wire signed [COORD_WIDTH-1:0] in_first_z,
  input  wire signed [COORD_WIDTH-1:0] in_second_x,
  input  wire signed [COORD_WIDTH-1:0] in_second_y,
  input  wire signed [COORD_WIDTH-1:0] in_second_z,
  input  wire signed [COORD_WIDTH-1:0] in_third_x,
  input  wire signed [COORD_WIDTH-1:0] in_third_y,
  input  wire signed [COORD_WIDTH-1:0] in_third_z,
  input  wire signed [NORM_W-1:0]      in_normal_x,
  input  wire signed [NORM_W-1:0]      in_normal_y,
  input  wire signed [NORM_W-1:0]      in_normal_z,
  output logic                         out_valid,
  output logic                         out_keep,
  output logic [1:0]                   out_reject_cause,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [CFG_W-1:0]             cfg_data
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // side difference magnitude
  localparam int SW   = W + 2;          // vertex sum magnitude
  localparam int DMW  = 2 * W + 2;      // squared vertex distance
  localparam int DH   = (DMW + 1) / 2;  // split of dmin for the ratio product
  localparam int RPW  = DMW + 2 * RATIO_W;
  localparam int NSW  = NORM_W + SW;
  localparam int AW   = NSW + 2;        // incidence accumulator
  localparam int AH   = AW / 2;
  localparam int SQW  = 2 * SW;
  localparam int SSW  = SQW + 2;        // squared centroid length (times 9)
  localparam int SH   = (SSW + 1) / 2;
  localparam int I2W  = 2 * INCID_W;
  localparam int IPW  = 2 * AW + 28;
  localparam int SQSW = 2 * SIDE_LOG + 2;
  localparam int NDEL = 28;             // flag delay from stage 6 to stage 34
  localparam int LAT  = 35;

  // ---------------------------------------------------------------- config
  logic [RATIO_W-1:0] ratio_lim_r;
  logic [PERIM_W-1:0] perim_lim_r;
  logic [INCID_W-1:0] incid_lim_r;
  logic [2*RATIO_W-1:0] rl2_r;
  logic [I2W-1:0]       il2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_lim_r <= '0;
      perim_lim_r <= '0;
      incid_lim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATIO:     ratio_lim_r <= cfg_data[RATIO_W-1:0];
        REG_PERIMETER: perim_lim_r <= cfg_data[PERIM_W-1:0];
        REG_INCIDENCE: incid_lim_r <= cfg_data[INCID_W-1:0];
        default: ;
      endcase
    end
  end

  // squared limits, kept in registers so no multiply chains into the datapath
  always_ff @(posedge clk) begin
    rl2_r <= ratio_lim_r * ratio_lim_r;
    il2_r <= incid_lim_r * incid_lim_r;
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------- valid line
  logic [LAT:1] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-1:1], start};
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [W-1:0]      vtx [3][3];
  logic signed [NORM_W-1:0] nrm [3];
  always_comb begin
    vtx[0][0] = in_first_x;  vtx[0][1] = in_first_y;  vtx[0][2] = in_first_z;
    vtx[1][0] = in_second_x; vtx[1][1] = in_second_y; vtx[1][2] = in_second_z;
    vtx[2][0] = in_third_x;  vtx[2][1] = in_third_y;  vtx[2][2] = in_third_z;
    nrm[0] = in_normal_x; nrm[1] = in_normal_y; nrm[2] = in_normal_z;
  end

  logic [2*W-1:0]    csq_r  [3][3];   // per-coordinate squares of vertices
  logic [DW-1:0]     dmag_r [3][3];   // side difference magnitudes
  logic [SW-1:0]     smag_r [3];      // vertex sum magnitudes
  logic [NORM_W-1:0] nmag_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        logic [W-1:0]     m;
        logic signed [W:0] df;
        logic signed [W:0] pa;
        logic signed [W:0] pb;
        m  = vtx[i][k][W-1] ? W'(-vtx[i][k]) : W'(vtx[i][k]);
        csq_r[i][k] <= m * m;
        // sides: 0 = v0-v1, 1 = v0-v2, 2 = v1-v2
        pa = (i == 2) ? DW'(vtx[1][k]) : DW'(vtx[0][k]);
        pb = (i == 0) ? DW'(vtx[1][k]) : DW'(vtx[2][k]);
        df = pa - pb;
        dmag_r[i][k] <= df[W] ? DW'(-df) : DW'(df);
      end
    end
    for (int k = 0; k < 3; k++) begin
      logic signed [SW-1:0] s;
      s = SW'(vtx[0][k]) + SW'(vtx[1][k]) + SW'(vtx[2][k]);
      smag_r[k] <= s[SW-1] ? SW'(-s) : SW'(s);
      nmag_r[k] <= nrm[k][NORM_W-1] ? NORM_W'(-nrm[k]) : NORM_W'(nrm[k]);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [DMW-1:0]        dist_r [3];
  logic [2*SIDE_LOG-1:0] dd_r   [3][3];
  logic [2:0]            long2_r;
  logic [NSW-1:0]        ns_r   [3];
  logic [SQW-1:0]        ssp_r  [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic lg;
      dist_r[i] <= DMW'(csq_r[i][0]) + DMW'(csq_r[i][1]) + DMW'(csq_r[i][2]);
      lg = 1'b0;
      for (int k = 0; k < 3; k++) begin
        logic [SIDE_LOG-1:0] d;
        d = SIDE_LOG'(dmag_r[i][k]);
        dd_r[i][k] <= d * d;
        lg = lg | ((dmag_r[i][k] >> SIDE_LOG) != '0);
      end
      long2_r[i] <= lg;
      ns_r[i]  <= nmag_r[i] * smag_r[i];
      ssp_r[i] <= smag_r[i] * smag_r[i];
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [RAD_W-1:0] rad3_r [3];
  logic             long3_r;
  logic [AW-1:0]    acc_r;
  logic [SSW-1:0]   ssq_r;
  logic [DMW-1:0]   dmax_r, dmin_r;

  always_ff @(posedge clk) begin
    logic [DMW-1:0] mx, mn;
    for (int i = 0; i < 3; i++) begin
      logic [SQSW-1:0] ss;
      ss = SQSW'(dd_r[i][0]) + SQSW'(dd_r[i][1]) + SQSW'(dd_r[i][2]);
      rad3_r[i] <= {ss, 8'd0};
    end
    long3_r <= |long2_r;
    acc_r   <= AW'(ns_r[0]) + AW'(ns_r[1]) + AW'(ns_r[2]);
    ssq_r   <= SSW'(ssp_r[0]) + SSW'(ssp_r[1]) + SSW'(ssp_r[2]);
    mx = dist_r[0];
    mn = dist_r[0];
    for (int i = 1; i < 3; i++) begin
      if (dist_r[i] > mx) mx = dist_r[i];
      if (dist_r[i] < mn) mn = dist_r[i];
    end
    dmax_r <= mx;
    dmin_r <= mn;
  end

  // ---------------------------------------------------------------- ratio and incidence, stages 4-6
  logic [RPW-1:0]   rlo_r, rhi_r, rprod_r;
  logic [DMW-1:0]   dmax4_r, dmax5_r;
  logic [2*AH-1:0]  all_r;
  logic [AW-1:0]    alh_r;
  logic [2*(AW-AH)-1:0] ahh_r;
  logic [IPW-1:0]   slo_r, shi_r, asq_r, sprod_r;
  flags_t           flg6_r;

  always_ff @(posedge clk) begin
    // stage 4: partial products
    rlo_r   <= RPW'(rl2_r * DH'(dmin_r));
    rhi_r   <= RPW'(rl2_r * (DMW-DH)'(dmin_r >> DH));
    dmax4_r <= dmax_r;
    all_r   <= AH'(acc_r) * AH'(acc_r);
    alh_r   <= AW'(AH'(acc_r) * (AW-AH)'(acc_r >> AH));
    ahh_r   <= (AW-AH)'(acc_r >> AH) * (AW-AH)'(acc_r >> AH);
    slo_r   <= IPW'(SH'(ssq_r) * il2_r);
    shi_r   <= IPW'((SSW-SH)'(ssq_r >> SH) * il2_r);
    // stage 5: recombine
    rprod_r <= (rhi_r << DH) + rlo_r;
    dmax5_r <= dmax4_r;
    asq_r   <= (IPW'(ahh_r) << (2 * AH)) + (IPW'(alh_r) << (AH + 1)) + IPW'(all_r);
    sprod_r <= (shi_r << SH) + slo_r;
    // stage 6: compare; acc scaled by 2^14, so acc^2 by 2^28
    flg6_r.ratio_fail <= !((RPW'(dmax5_r) << 16) < rprod_r);
    flg6_r.incid_fail <= !(sprod_r < (asq_r << 28));
  end

  flags_t flg_del_r [NDEL];
  always_ff @(posedge clk) begin
    flg_del_r[0] <= flg6_r;
    for (int k = 1; k < NDEL; k++) flg_del_r[k] <= flg_del_r[k-1];
  end

  // ---------------------------------------------------------------- side roots, stages 4-34
  // restoring square root, one root bit per stage, high bit first
  logic [RAD_W-1:0]  rem_r  [ROOT_W][3];
  logic [ROOT_W-1:0] root_r [ROOT_W][3];
  logic              long_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam int B = ROOT_W - 1 - j;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        logic [RAD_W-1:0]  rin, trial;
        logic [ROOT_W-1:0] qin;
        if (j == 0) begin
          rin = rad3_r[i];
          qin = '0;
        end else begin
          rin = rem_r[(j == 0) ? 0 : j-1][i];
          qin = root_r[(j == 0) ? 0 : j-1][i];
        end
        trial = (RAD_W'(qin) << (B + 1)) | (RAD_W'(1) << (2 * B));
        if (rin >= trial) begin
          rem_r[j][i]  <= rin - trial;
          root_r[j][i] <= qin | (ROOT_W'(1) << B);
        end else begin
          rem_r[j][i]  <= rin;
          root_r[j][i] <= qin;
        end
      end
      long_r[j] <= (j == 0) ? long3_r : long_r[(j == 0) ? 0 : j-1];
    end
  end

  // ---------------------------------------------------------------- stage 35: decision
  logic [ROOT_W+1:0] perim_sum;
  logic              perim_fail;
  cause_t            cause;
  flags_t            flg34;

  always_comb begin
    flg34 = flg_del_r[NDEL-1];
    perim_sum = (ROOT_W+2)'(root_r[ROOT_W-1][0]) + (ROOT_W+2)'(root_r[ROOT_W-1][1])
              + (ROOT_W+2)'(root_r[ROOT_W-1][2]);
    perim_fail = long_r[ROOT_W-1] || !(perim_sum < (ROOT_W+2)'({perim_lim_r, 4'd0}));
    if (ratio_lim_r != '0 && flg34.ratio_fail)       cause = CAUSE_RATIO;
    else if (perim_lim_r != '0 && perim_fail)        cause = CAUSE_PERIMETER;
    else if (incid_lim_r != '0 && flg34.incid_fail)  cause = CAUSE_INCIDENCE;
    else                                             cause = CAUSE_KEPT;
  end

  logic [1:0] cause_r;
  always_ff @(posedge clk) cause_r <= cause;

  assign out_valid        = vld_r[LAT];
  assign out_reject_cause = cause_r;
  assign out_keep         = (cause_r == CAUSE_KEPT);

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##35 out_valid)
    else $error("item lost in pipeline");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 35))
    else $error("result without an item");

  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ratio_lim_r == '0) |-> (out_reject_cause != CAUSE_RATIO))
    else $error("disabled ratio test rejected");

endmodule
`default_nettype wire
